// File: rtl/lbvs_pkg.sv
package lbvs_pkg;

  localparam int unsigned MatWords = 12;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdSkin = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgWeightFormat    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgWeightThreshold = 8'd1;

  typedef struct packed {
    logic               command;
    logic [5:0]         palette_bone;
    logic [3:0]         palette_element;
    logic signed [31:0] palette_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic [63:0]        blend_weights;
    logic [31:0]        blend_bones;
  } lbvs_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_nrm_x;
    logic signed [31:0] out_nrm_y;
    logic signed [31:0] out_nrm_z;
  } lbvs_out_t;

  // round(b * 32768 / 255) via a reciprocal that never overshoots, plus one correction.
  function automatic logic [15:0] byte_to_q15(input logic [7:0] b);
    logic [22:0] x;
    logic [38:0] prod;
    logic [15:0] q0;
    logic [23:0] r;
    x    = {b, 15'b0} + 23'd127;
    prod = 39'(x) * 39'd32896;
    q0   = prod[38:23];
    r    = 24'(x) - 24'(q0) * 24'd255;
    return (r >= 24'd255) ? q0 + 16'd1 : q0;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// File: rtl/lbvs_stream_if.sv
interface lbvs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/lbvs_cfg_if.sv
interface lbvs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lbvs_pkg::CfgIdxW-1:0]   index;
  logic [31:0]                    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/linear_blend_vertex_skinning_core.sv
// Four-influence linear blend skinning with a local bone matrix palette.
// Input channel in_i carries load items (one Q16.16 palette word, no result)
// and vertex items (position, normal, bone indices, weights). Each vertex
// gives exactly one transfer on out_o with the saturated skinned position
// and normal. Register writes on cfg_i are always taken; they may only be
// issued while no vertex is in flight.
// Throughput is one item per cycle while the receiver does not stall: every
// influence lane has its own copy of the palette (one memory per matrix
// word), so all bones of a vertex are read at once. Result valid is
// registered through five register stages: palette read, products, row
// sums, weighting, lane sum and rounding.
// A receiver stall freezes the whole pipeline and drops in_i.ready in the
// same cycle; nothing is lost or repeated. Reset clears the valid bits and
// the registers (Q1.15 weights, zero threshold); the palette holds no
// defined value until it is loaded.
module linear_blend_vertex_skinning_core #(
  parameter int unsigned PALETTE_BONES = 64,
  parameter int unsigned INFLUENCES    = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lbvs_stream_if.sink    in_i,
  lbvs_stream_if.source  out_o,
  lbvs_cfg_if.sink       cfg_i
);
  import lbvs_pkg::*;

  localparam int unsigned AddrW = (PALETTE_BONES > 1) ? $clog2(PALETTE_BONES) : 1;

  logic        weight_format_q;
  logic [15:0] weight_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_format_q    <= 1'b0;
      weight_threshold_q <= 16'd0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgWeightFormat:    weight_format_q    <= cfg_i.data[0];
        CfgWeightThreshold: weight_threshold_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end
  assign cfg_i.ready = 1'b1;

  logic adv, accept, load_we;
  logic out_valid_q;
  logic [8:0] wr_bone_ext;
  logic [AddrW-1:0] wr_addr;

  assign adv    = !out_valid_q || out_o.ready;
  assign accept = in_i.valid && adv;
  assign in_i.ready = adv;

  assign wr_bone_ext = {3'b0, in_i.data.palette_bone};
  assign wr_addr     = wr_bone_ext[AddrW-1:0];
  assign load_we = accept && (in_i.data.command == CmdLoad)
                && (wr_bone_ext < 9'(PALETTE_BONES))
                && (in_i.data.palette_element < 4'(MatWords));

  // Stage 1: palette read and input capture.
  logic [AddrW-1:0]   rd_addr [INFLUENCES];
  logic               bone_ok [INFLUENCES];
  logic signed [31:0] mat_q   [INFLUENCES][MatWords];
  logic               bone_ok1_q [INFLUENCES];
  logic signed [31:0] vec1_q [6];
  logic [63:0]        wts1_q;
  logic               v1_q;

  for (genvar l = 0; l < INFLUENCES; l++) begin : g_lane
    logic [8:0] bone_ext;
    assign bone_ext   = {1'b0, in_i.data.blend_bones[8*l +: 8]};
    assign rd_addr[l] = bone_ext[AddrW-1:0];
    assign bone_ok[l] = bone_ext < 9'(PALETTE_BONES);

    for (genvar e = 0; e < MatWords; e++) begin : g_word
      logic [31:0] mem [PALETTE_BONES];
      always_ff @(posedge clk_i) begin
        if (load_we && (in_i.data.palette_element == 4'(e))) begin
          mem[wr_addr] <= in_i.data.palette_value;
        end
        if (adv) begin
          mat_q[l][e] <= mem[rd_addr[l]];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vec1_q[0] <= in_i.data.pos_x;
      vec1_q[1] <= in_i.data.pos_y;
      vec1_q[2] <= in_i.data.pos_z;
      vec1_q[3] <= in_i.data.nrm_x;
      vec1_q[4] <= in_i.data.nrm_y;
      vec1_q[5] <= in_i.data.nrm_z;
      wts1_q    <= in_i.data.blend_weights;
      for (int l = 0; l < INFLUENCES; l++) bone_ok1_q[l] <= bone_ok[l];
    end
  end

  // Stage 2: matrix products; rows 0..2 are position, 3..5 are normal.
  // A lane that does not count carries a zero weight from here on.
  logic signed [63:0] prod_q  [INFLUENCES][6][3];
  logic signed [31:0] trans_q [INFLUENCES][3];
  logic [15:0]        w_d     [INFLUENCES];
  logic [15:0]        w2_q    [INFLUENCES];
  logic               v2_q;

  always_comb begin
    logic [15:0] raw;
    logic [15:0] wsel;
    for (int l = 0; l < INFLUENCES; l++) begin
      raw  = wts1_q[16*l +: 16];
      wsel = weight_format_q ? byte_to_q15(raw[7:0]) : raw;
      w_d[l] = ((wsel > weight_threshold_q) && bone_ok1_q[l]) ? wsel : 16'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < INFLUENCES; l++) begin
        w2_q[l] <= w_d[l];
        for (int r = 0; r < 3; r++) begin
          trans_q[l][r] <= mat_q[l][r*4+3];
          for (int c = 0; c < 3; c++) begin
            prod_q[l][r][c]   <= mat_q[l][r*4+c] * vec1_q[c];
            prod_q[l][r+3][c] <= mat_q[l][r*4+c] * vec1_q[c+3];
          end
        end
      end
    end
  end

  // Stage 3: round each product to Q16.16, sum the row with the translation for position rows, saturate.
  logic signed [31:0] t_d  [INFLUENCES][6];
  logic signed [31:0] t3_q [INFLUENCES][6];
  logic [15:0]        w3_q [INFLUENCES];
  logic               v3_q;

  always_comb begin
    logic signed [49:0] sum;
    logic signed [63:0] rp;
    for (int l = 0; l < INFLUENCES; l++) begin
      for (int k = 0; k < 6; k++) begin
        sum = (k < 3) ? 50'(trans_q[l][k % 3]) : 50'sd0;
        for (int c = 0; c < 3; c++) begin
          rp  = (prod_q[l][k][c] + 64'sd32768) >>> 16;
          sum = sum + 50'(rp);
        end
        t_d[l][k] = sat32(64'(sum));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < INFLUENCES; l++) begin
        w3_q[l] <= w2_q[l];
        for (int k = 0; k < 6; k++) t3_q[l][k] <= t_d[l][k];
      end
    end
  end

  // Stage 4: weighting. A lane that does not count may have read a palette
  // entry that holds no value, so its product is forced to zero.
  logic signed [48:0] wp_q [INFLUENCES][6];
  logic               v4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < INFLUENCES; l++) begin
        for (int k = 0; k < 6; k++) begin
          wp_q[l][k] <= (w3_q[l] == 16'd0) ? 49'sd0
                      : t3_q[l][k] * $signed({1'b0, w3_q[l]});
        end
      end
    end
  end

  // Stage 5: lane sum, round from Q.15 weights, saturate into the output register.
  logic signed [31:0] res_d [6];
  lbvs_out_t          out_q;

  always_comb begin
    logic signed [50:0] acc;
    logic signed [50:0] rnd;
    for (int k = 0; k < 6; k++) begin
      acc = 51'sd0;
      for (int l = 0; l < INFLUENCES; l++) acc = acc + 51'(wp_q[l][k]);
      rnd = (acc + 51'sd16384) >>> 15;
      res_d[k] = sat32(64'(rnd));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v4_q) begin
      out_q.out_pos_x <= res_d[0];
      out_q.out_pos_y <= res_d[1];
      out_q.out_pos_z <= res_d[2];
      out_q.out_nrm_x <= res_d[3];
      out_q.out_nrm_y <= res_d[4];
      out_q.out_nrm_z <= res_d[5];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= accept && (in_i.data.command == CmdSkin);
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// File: rtl/lbvs_checker.sv
module lbvs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                cfg_ready,
  input lbvs_pkg::lbvs_out_t out_data
);
  import lbvs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_data)) else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("input blocked with empty output register");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("input taken during output stall");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready) else $error("register write refused");

endmodule

bind linear_blend_vertex_skinning_core lbvs_checker u_lbvs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .cfg_ready (cfg_i.ready),
  .out_data  (out_o.data)
);
